[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/ccd_pkg.sv]
// ----------------------------------------------------------------------------
// ccd_pkg
// Types, character codes and small decode functions for the character
// constant decoder.
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned CountW  = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned EscW    = 9;

  localparam logic [CountW-1:0] CountMax = 4'd9;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_UNTERM   = 3'd1;
  localparam logic [StatusW-1:0] ST_BAD_ESC  = 3'd2;
  localparam logic [StatusW-1:0] ST_RANGE    = 3'd3;
  localparam logic [StatusW-1:0] ST_BAD_LEN  = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;

  localparam logic [7:0] HighNibble = 8'hF0;
  localparam logic [8:0] ByteMax    = 9'h0FF;

  typedef enum logic [5:0] {
    MODE_BODY = 6'b000001,
    MODE_ESC  = 6'b000010,
    MODE_OCT1 = 6'b000100,
    MODE_OCT2 = 6'b001000,
    MODE_HEX0 = 6'b010000,
    MODE_HEXN = 6'b100000
  } mode_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     is_long;
    logic [CountW-1:0]        char_count;
    logic [StatusW-1:0]       status;
  } result_t;

  function automatic logic is_oct(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h37);
  endfunction

  // Returns {valid, digit}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      r = {1'b1, b[3:0]};
    end else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Returns {valid, character}.
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h61:     r = {1'b1, 8'd7};
      8'h62:     r = {1'b1, 8'd8};
      8'h66:     r = {1'b1, 8'd12};
      8'h6E:     r = {1'b1, 8'd10};
      8'h72:     r = {1'b1, 8'd13};
      8'h74:     r = {1'b1, 8'd9};
      8'h76:     r = {1'b1, 8'd11};
      CH_QMARK:  r = {1'b1, b};
      CH_DQUOTE: r = {1'b1, b};
      CH_BSLASH: r = {1'b1, b};
      CH_QUOTE:  r = {1'b1, b};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [CountW-1:0] count_inc(input logic [CountW-1:0] c);
    return (c >= CountMax) ? CountMax : c + 4'd1;
  endfunction

endpackage

[rtl/c_char_constant_decoder.sv]
// A terminator's result is registered in the output register, or in the skid entry on a stall.
// Throughput: one byte per cycle if not stalled; mode, escape and accumulator update in one pass.
// The result side has an output register plus one skid entry, so input stalls only when both hold.
// Reset: synchronous, active low; returns to body mode with empty accumulator and no error.
// ----------------------------------------------------------------------------
// c_char_constant_decoder
// Decodes the bytes of a C character constant after its opening quote,
// handling octal, hex and simple escapes, and emits one result beat per
// terminator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c_char_constant_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_byte_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ccd_pkg::ValueW-1:0]   out_value,
  output logic                                out_is_long,
  output logic [ccd_pkg::CountW-1:0]          out_char_count,
  output logic [ccd_pkg::StatusW-1:0]         out_status
);
  import ccd_pkg::*;

  mode_t                mode_r, mode_nxt;
  logic [EscW-1:0]      esc_r, esc_nxt;
  logic [ValueW-1:0]    acc_r, acc_nxt;
  logic [CountW-1:0]    cnt_r, cnt_nxt;
  logic [StatusW-1:0]   err_r, err_nxt;

  logic                 out_valid_r, skid_valid_r;
  result_t              out_res_r, skid_res_r;
  result_t              res_nxt;

  logic                 accept, emit;
  logic [7:0]           b;
  logic [4:0]           hex;
  logic [8:0]           simple;
  logic [EscW-1:0]      oct_val;

  logic                 put1, err_set, do_body, fin;
  logic [7:0]           put1_c;
  logic [StatusW-1:0]   err_code;
  logic [ValueW-1:0]    acc1;
  logic [CountW-1:0]    cnt1;
  logic [StatusW-1:0]   err1, status;

  assign b        = in_byte_in;
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign hex      = hex_digit(b);
  assign simple   = simple_escape(b);
  assign oct_val  = {esc_r[5:0], b[2:0]};

  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    put1     = 1'b0;
    put1_c   = 8'd0;
    err_set  = 1'b0;
    err_code = ST_OK;
    do_body  = 1'b0;
    fin      = 1'b0;
    case (mode_r)
      MODE_ESC: begin
        if (is_oct(b)) begin
          esc_nxt  = {6'd0, b[2:0]};
          mode_nxt = MODE_OCT1;
        end else if (b == CH_X) begin
          esc_nxt  = '0;
          mode_nxt = MODE_HEX0;
        end else begin
          mode_nxt = MODE_BODY;
          if (simple[8]) begin
            put1   = 1'b1;
            put1_c = simple[7:0];
          end else begin
            err_set  = 1'b1;
            err_code = ST_BAD_ESC;
            fin      = (b == CH_NUL) || (b == CH_NL);
          end
        end
      end
      MODE_OCT1: begin
        if (is_oct(b)) begin
          esc_nxt  = oct_val;
          mode_nxt = MODE_OCT2;
        end else begin
          put1    = 1'b1;
          put1_c  = esc_r[7:0];
          do_body = 1'b1;
        end
      end
      MODE_OCT2: begin
        put1 = 1'b1;
        if (is_oct(b)) begin
          esc_nxt  = oct_val;
          put1_c   = oct_val[7:0];
          err_set  = oct_val > ByteMax;
          err_code = ST_RANGE;
          mode_nxt = MODE_BODY;
        end else begin
          put1_c  = esc_r[7:0];
          do_body = 1'b1;
        end
      end
      MODE_HEX0: begin
        if (hex[4]) begin
          esc_nxt  = {5'd0, hex[3:0]};
          mode_nxt = MODE_HEXN;
        end else begin
          err_set  = 1'b1;
          err_code = ST_BAD_ESC;
          do_body  = 1'b1;
        end
      end
      MODE_HEXN: begin
        if (hex[4]) begin
          err_set  = (esc_r[7:0] & HighNibble) != 8'd0;
          err_code = ST_RANGE;
          esc_nxt  = {1'b0, esc_r[3:0], hex[3:0]};
        end else begin
          put1    = 1'b1;
          put1_c  = esc_r[7:0];
          do_body = 1'b1;
        end
      end
      default: begin
        do_body = 1'b1;
      end
    endcase

    acc1 = put1 ? {acc_r[ValueW-9:0], put1_c} : acc_r;
    cnt1 = put1 ? count_inc(cnt_r) : cnt_r;
    err1 = (err_set && (err_r == ST_OK)) ? err_code : err_r;

    acc_nxt = acc1;
    cnt_nxt = cnt1;
    err_nxt = err1;
    if (do_body) begin
      mode_nxt = MODE_BODY;
      if ((b == CH_NUL) || (b == CH_NL) || (b == CH_QUOTE)) begin
        fin = 1'b1;
      end else if (b == CH_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else begin
        acc_nxt = {acc1[ValueW-9:0], b};
        cnt_nxt = count_inc(cnt1);
      end
    end

    status = err1;
    if ((status == ST_OK) && (b != CH_QUOTE)) begin
      status = ST_UNTERM;
    end
    if ((status == ST_OK) && ((cnt1 == 4'd0) || (cnt1 > 4'd8))) begin
      status = ST_BAD_LEN;
    end

    res_nxt.value      = '0;
    res_nxt.is_long    = 1'b0;
    res_nxt.char_count = cnt1;
    res_nxt.status     = status;
    if (cnt1 == 4'd1) begin
      res_nxt.value = {{(ValueW-8){acc1[7]}}, acc1[7:0]};
    end else if ((cnt1 >= 4'd2) && (cnt1 <= 4'd4)) begin
      res_nxt.value = {{(ValueW-32){acc1[31]}}, acc1[31:0]};
    end else if ((cnt1 >= 4'd5) && (cnt1 <= 4'd8)) begin
      res_nxt.value   = acc1;
      res_nxt.is_long = 1'b1;
    end

    if (fin) begin
      mode_nxt = MODE_BODY;
      esc_nxt  = '0;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      err_nxt  = ST_OK;
    end
  end

  assign emit = accept && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BODY;
      esc_r  <= '0;
      acc_r  <= '0;
      cnt_r  <= '0;
      err_r  <= ST_OK;
    end else if (accept) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= emit;
      end
    end else if (emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
      end else if (emit) begin
        out_res_r <= res_nxt;
      end
    end else if (emit) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_res_r.value;
  assign out_is_long    = out_res_r.is_long;
  assign out_char_count = out_res_r.char_count;
  assign out_status     = out_res_r.status;

  `ASSERT_ALWAYS(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid beat without output beat")
  `ASSERT_CLK(a_skid_drains, (skid_valid_r && !out_stall) |=> (out_valid_r && !skid_valid_r), "skid beat not moved to output")
  `ASSERT_CLK(a_clear_after_emit, emit |=> ((mode_r == MODE_BODY) && (cnt_r == 4'd0) && (err_r == ST_OK) && (acc_r == '0)), "state not cleared after terminator")
  `ASSERT_CLK(a_ok_length, (out_valid_r && (out_res_r.status == ST_OK)) |-> ((out_res_r.char_count != 4'd0) && (out_res_r.char_count <= 4'd8)), "ok status with bad length")
  `ASSERT_CLK(a_count_sat, cnt_r <= CountMax, "character count above saturation")

endmodule

[tb/c_char_constant_decoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_char_constant_decoder_test
// Feeds byte streams of C character constants to the decoder and checks every
// result beat against a cycle-free decoder model kept in this module. Directed
// constants cover the escape and error cases, then random constants run under
// several sender and receiver idle patterns, a long receiver hold-off and a
// sender that waits for every result before the next constant.
// ----------------------------------------------------------------------------
module c_char_constant_decoder_test;
  import ccd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte_in = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ValueW-1:0] out_value;
  logic out_is_long;
  logic [CountW-1:0] out_char_count;
  logic [StatusW-1:0] out_status;

  c_char_constant_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte_in(in_byte_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .out_is_long(out_is_long),
    .out_char_count(out_char_count),
    .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] pending_bytes[$];
  result_t decoded_q[$];
  int bytes_outstanding = 0;
  int bytes_queued = 0;
  int error_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit byte_taken = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  mode_t scan_mode = MODE_BODY;
  logic [EscW-1:0] esc_val = '0;
  logic [ValueW-1:0] char_acc = '0;
  logic [CountW-1:0] char_total = '0;
  logic [StatusW-1:0] held_error = ST_OK;

  logic [7:0] escape_letters [11] = '{"a", "b", "f", "n", "r", "t", "v",
                                      CH_QMARK, CH_DQUOTE, CH_BSLASH, CH_QUOTE};

  function automatic bit is_octal(input logic [7:0] b);
    return b >= "0" && b <= "7";
  endfunction

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic int escape_char(input logic [7:0] b);
    case (b)
      "a": return 7;
      "b": return 8;
      "f": return 12;
      "n": return 10;
      "r": return 13;
      "t": return 9;
      "v": return 11;
      CH_QMARK, CH_DQUOTE, CH_BSLASH, CH_QUOTE: return int'(b);
      default: return -1;
    endcase
  endfunction

  task automatic add_char(input logic [7:0] c);
    char_acc = {char_acc[ValueW-9:0], c};
    if (char_total < CountMax) char_total++;
  endtask

  task automatic note_status(input logic [StatusW-1:0] e);
    if (held_error == ST_OK) held_error = e;
  endtask

  task automatic close_constant(input logic [7:0] b);
    result_t r;
    r.status = held_error;
    if (r.status == ST_OK && b != CH_QUOTE) r.status = ST_UNTERM;
    if (r.status == ST_OK && (char_total == 0 || char_total > 8)) r.status = ST_BAD_LEN;
    r.value = '0;
    r.is_long = 1'b0;
    if (char_total == 1) begin
      r.value = {{56{char_acc[7]}}, char_acc[7:0]};
    end else if (char_total >= 2 && char_total <= 4) begin
      r.value = {{32{char_acc[31]}}, char_acc[31:0]};
    end else if (char_total >= 5 && char_total <= 8) begin
      r.value = char_acc;
      r.is_long = 1'b1;
    end
    r.char_count = char_total;
    decoded_q.push_back(r);
    scan_mode = MODE_BODY;
    esc_val = '0;
    char_acc = '0;
    char_total = '0;
    held_error = ST_OK;
  endtask

  task automatic body_char(input logic [7:0] b);
    scan_mode = MODE_BODY;
    if (b == CH_NUL || b == CH_NL || b == CH_QUOTE) begin
      close_constant(b);
    end else if (b == CH_BSLASH) begin
      scan_mode = MODE_ESC;
    end else begin
      add_char(b);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int hd;
    int sc;
    hd = hex_nibble(b);
    sc = escape_char(b);
    case (scan_mode)
      MODE_ESC: begin
        if (is_octal(b)) begin
          esc_val = {6'd0, b[2:0]};
          scan_mode = MODE_OCT1;
        end else if (b == CH_X) begin
          esc_val = '0;
          scan_mode = MODE_HEX0;
        end else begin
          scan_mode = MODE_BODY;
          if (sc >= 0) begin
            add_char(sc[7:0]);
          end else begin
            note_status(ST_BAD_ESC);
            if (b == CH_NUL || b == CH_NL) close_constant(b);
          end
        end
      end
      MODE_OCT1: begin
        if (is_octal(b)) begin
          esc_val = {esc_val[5:0], b[2:0]};
          scan_mode = MODE_OCT2;
        end else begin
          add_char(esc_val[7:0]);
          body_char(b);
        end
      end
      MODE_OCT2: begin
        if (is_octal(b)) begin
          esc_val = {esc_val[5:0], b[2:0]};
          if (esc_val > ByteMax) note_status(ST_RANGE);
          add_char(esc_val[7:0]);
          scan_mode = MODE_BODY;
        end else begin
          add_char(esc_val[7:0]);
          body_char(b);
        end
      end
      MODE_HEX0: begin
        if (hd >= 0) begin
          esc_val = {5'd0, hd[3:0]};
          scan_mode = MODE_HEXN;
        end else begin
          note_status(ST_BAD_ESC);
          body_char(b);
        end
      end
      MODE_HEXN: begin
        if (hd >= 0) begin
          if ((esc_val[7:0] & HighNibble) != 0) note_status(ST_RANGE);
          esc_val = {1'b0, esc_val[3:0], hd[3:0]};
        end else begin
          add_char(esc_val[7:0]);
          body_char(b);
        end
      end
      default: body_char(b);
    endcase
  endtask

  // Sender: a beat stays on the bus until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      byte_taken = 1'b0;
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_byte_in <= pending_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 80;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte_in);
        bytes_outstanding--;
        byte_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("result beat with no constant pending: value %0d status %0d",
                 out_value, out_status);
          error_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_value);
            error_count++;
          end
          if (out_is_long !== want.is_long) begin
            $error("is_long: expected %0d, got %0d", want.is_long, out_is_long);
            error_count++;
          end
          if (out_char_count !== want.char_count) begin
            $error("char_count: expected %0d, got %0d", want.char_count, out_char_count);
            error_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            error_count++;
          end
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_outstanding++;
    bytes_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CH_NUL || b == CH_NL || b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] hex_char();
    int d;
    d = $urandom_range(15);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
  endfunction

  task automatic queue_constant(input bit noisy);
    int n;
    int digits;
    n = ($urandom_range(9) == 0) ? $urandom_range(10) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(3) == 0) begin
        queue_byte(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(9))
          5, 6: begin
            queue_byte(CH_BSLASH);
            queue_byte(escape_letters[$urandom_range(10)]);
          end
          7: begin
            queue_byte(CH_BSLASH);
            digits = $urandom_range(1, 3);
            repeat (digits) queue_byte(8'("0" + $urandom_range(7)));
          end
          8: begin
            queue_byte(CH_BSLASH);
            queue_byte(CH_X);
            digits = $urandom_range(1, 3);
            repeat (digits) queue_byte(hex_char());
          end
          9: begin
            queue_byte(CH_BSLASH);
            queue_byte($urandom_range(1) ? CH_X : 8'($urandom_range(255)));
          end
          default: queue_byte(plain_byte());
        endcase
      end
    end
    case ($urandom_range(19))
      0: queue_byte(CH_NL);
      1: queue_byte(CH_NUL);
      default: queue_byte(CH_QUOTE);
    endcase
  endtask

  task automatic wait_idle();
    while (bytes_outstanding != 0 || decoded_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int nbytes);
    int stop_at;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    stop_at = bytes_queued + nbytes;
    while (bytes_queued < stop_at) queue_constant($urandom_range(9) == 0);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_byte(8'hFF);
    queue_byte(CH_QUOTE);
    queue_byte(CH_QUOTE);
    queue_text("\\q'");
    queue_text("\\x'");
    queue_text("\\400'");
    queue_text("\\x1ff'");
    queue_text("\\7A\n");
    queue_byte(CH_BSLASH);
    queue_byte(CH_NUL);
    wait_idle();

    run_phase(0, 0, 120);
    run_phase(53, 0, 110);
    run_phase(0, 53, 110);
    run_phase(22, 22, 110);

    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    repeat (12) begin
      queue_text("a'");
      queue_byte(CH_QUOTE);
    end
    wait_idle();

    send_idle_pct = 22;
    stall_pct = 22;
    repeat (10) begin
      queue_constant(1'b0);
      wait_idle();
    end

    repeat (5) @(negedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
